// ===== rtl/eis_pkg.sv =====
// ----------------------------------------------------------------------------
// eis_pkg
// shared types, constants and the coefficient selection table of the scorer
// ----------------------------------------------------------------------------
`default_nettype none

package eis_pkg;

  localparam int unsigned COUNT_BITS = 16;
  localparam int unsigned NUM_REGS   = 8;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned F_W        = 48;
  localparam int unsigned COORD_W    = 16;
  localparam int unsigned COEF_W     = 62;
  localparam int unsigned MAG_W      = 61;
  localparam int unsigned NUM_W      = 53;
  localparam int unsigned NMAG_W     = 51;
  localparam int unsigned CHUNK_W    = 17;
  localparam int unsigned SQ_W       = 102;
  localparam int unsigned N2_W       = 61;
  localparam int unsigned REM_W      = 93;
  localparam int unsigned DVS_W      = 92;
  localparam int unsigned ERR_W      = 32;
  localparam int unsigned TOTAL_W    = 16;
  localparam int unsigned CNT_W      = 5;
  localparam int unsigned SEL_W      = 2;
  localparam int unsigned FIDX_W     = 4;

  localparam logic [31:0] ERR_LIMIT  = 32'd51200;
  localparam logic [46:0] C_LIMIT    = 47'h4000_0000_0000;
  localparam logic [FIDX_W-1:0] FIDX_ONE = 4'd8;

  localparam logic [CNT_W-1:0] COEF_LAST = 5'd5;
  localparam logic [CNT_W-1:0] NUM_LAST  = 5'd2;
  localparam logic [CNT_W-1:0] N2_LAST   = 5'd1;
  localparam logic [CNT_W-1:0] SQ_LAST   = 5'd2;
  localparam logic [CNT_W-1:0] DIV_LAST  = 5'd31;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_COEF,
    ST_NORM_INIT,
    ST_NORM,
    ST_NUM,
    ST_N2,
    ST_SQ,
    ST_DIV_INIT,
    ST_DIV,
    ST_TERM,
    ST_FINISH
  } state_e;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_COEF_X,
    OP_COEF_Y,
    OP_NORM_INIT,
    OP_NORM_STEP,
    OP_NUM_C,
    OP_NUM_A,
    OP_NUM_B,
    OP_N2_A,
    OP_N2_B,
    OP_SQ,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_TERM,
    OP_FINISH
  } dp_op_e;

  typedef struct packed {
    dp_op_e             op;
    logic               line;
    logic [SEL_W-1:0]   sel;
  } cmd_t;

  typedef struct packed {
    logic degen;
    logic norm_done;
  } status_t;

  // which F entry feeds coefficient sel of a line: x term, y term, constant
  function automatic logic [FIDX_W-1:0] f_index(input logic line, input logic [SEL_W-1:0] sel,
                                                input logic [1:0] part);
    logic [FIDX_W-1:0] r;
    r = FIDX_ONE;
    if (!line) begin
      if (sel == 2'd2 && part == 2'd2) r = FIDX_ONE;
      else r = 4'(3 * sel + part);
    end else begin
      if (sel == 2'd2 && part == 2'd2) r = FIDX_ONE;
      else r = 4'(sel + 3 * part);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/eis_ctrl.sv =====
// ----------------------------------------------------------------------------
// eis_ctrl
// sequencer: steps the datapath through both lines of a pair and the result
// ----------------------------------------------------------------------------
`default_nettype none

module eis_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  input  eis_pkg::status_t    status_i,
  output eis_pkg::cmd_t       cmd_o
);

  eis_pkg::state_e                 state_q, state_d;
  logic [eis_pkg::CNT_W-1:0]       cnt_q, cnt_d;
  logic                            line_q, line_d;
  logic                            out_valid_q, out_valid_d;
  logic                            out_free;
  logic                            finish_fire;

  assign out_free    = !out_valid_q || out_ready_i;
  assign finish_fire = (state_q == eis_pkg::ST_FINISH) && out_free;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    line_d  = line_q;
    unique case (state_q)
      eis_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = eis_pkg::ST_COEF;
          cnt_d   = '0;
          line_d  = 1'b0;
        end
      end
      eis_pkg::ST_COEF: begin
        if (cnt_q == eis_pkg::COEF_LAST) begin
          state_d = eis_pkg::ST_NORM_INIT;
          cnt_d   = '0;
        end else cnt_d = cnt_q + 1'b1;
      end
      eis_pkg::ST_NORM_INIT: begin
        if (status_i.degen) begin
          if (line_q) state_d = eis_pkg::ST_FINISH;
          else begin
            state_d = eis_pkg::ST_COEF;
            line_d  = 1'b1;
            cnt_d   = '0;
          end
        end else state_d = eis_pkg::ST_NORM;
      end
      eis_pkg::ST_NORM: begin
        if (status_i.norm_done) begin
          state_d = eis_pkg::ST_NUM;
          cnt_d   = '0;
        end
      end
      eis_pkg::ST_NUM: begin
        if (cnt_q == eis_pkg::NUM_LAST) begin
          state_d = eis_pkg::ST_N2;
          cnt_d   = '0;
        end else cnt_d = cnt_q + 1'b1;
      end
      eis_pkg::ST_N2: begin
        if (cnt_q == eis_pkg::N2_LAST) begin
          state_d = eis_pkg::ST_SQ;
          cnt_d   = '0;
        end else cnt_d = cnt_q + 1'b1;
      end
      eis_pkg::ST_SQ: begin
        if (cnt_q == eis_pkg::SQ_LAST) begin
          state_d = eis_pkg::ST_DIV_INIT;
          cnt_d   = '0;
        end else cnt_d = cnt_q + 1'b1;
      end
      eis_pkg::ST_DIV_INIT: begin
        state_d = eis_pkg::ST_DIV;
        cnt_d   = '0;
      end
      eis_pkg::ST_DIV: begin
        if (cnt_q == eis_pkg::DIV_LAST) state_d = eis_pkg::ST_TERM;
        else cnt_d = cnt_q + 1'b1;
      end
      eis_pkg::ST_TERM: begin
        if (line_q) state_d = eis_pkg::ST_FINISH;
        else begin
          state_d = eis_pkg::ST_COEF;
          line_d  = 1'b1;
          cnt_d   = '0;
        end
      end
      eis_pkg::ST_FINISH: begin
        if (out_free) state_d = eis_pkg::ST_IDLE;
      end
      default: state_d = eis_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '{op: eis_pkg::OP_NOP, line: line_q, sel: cnt_q[eis_pkg::SEL_W-1:0]};
    in_ready_o = 1'b0;
    unique case (state_q)
      eis_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) cmd_o.op = eis_pkg::OP_LOAD;
      end
      eis_pkg::ST_COEF: begin
        cmd_o.op  = cnt_q[0] ? eis_pkg::OP_COEF_Y : eis_pkg::OP_COEF_X;
        cmd_o.sel = cnt_q[2:1];
      end
      eis_pkg::ST_NORM_INIT: cmd_o.op = eis_pkg::OP_NORM_INIT;
      eis_pkg::ST_NORM: begin
        if (!status_i.norm_done) cmd_o.op = eis_pkg::OP_NORM_STEP;
      end
      eis_pkg::ST_NUM: begin
        unique case (cnt_q[1:0])
          2'd0:    cmd_o.op = eis_pkg::OP_NUM_C;
          2'd1:    cmd_o.op = eis_pkg::OP_NUM_A;
          default: cmd_o.op = eis_pkg::OP_NUM_B;
        endcase
      end
      eis_pkg::ST_N2:       cmd_o.op = cnt_q[0] ? eis_pkg::OP_N2_B : eis_pkg::OP_N2_A;
      eis_pkg::ST_SQ:       cmd_o.op = eis_pkg::OP_SQ;
      eis_pkg::ST_DIV_INIT: cmd_o.op = eis_pkg::OP_DIV_INIT;
      eis_pkg::ST_DIV:      cmd_o.op = eis_pkg::OP_DIV_STEP;
      eis_pkg::ST_TERM:     cmd_o.op = eis_pkg::OP_TERM;
      eis_pkg::ST_FINISH: begin
        if (out_free) cmd_o.op = eis_pkg::OP_FINISH;
      end
      default: cmd_o.op = eis_pkg::OP_NOP;
    endcase
  end

  assign out_valid_d = finish_fire ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= eis_pkg::ST_IDLE;
      cnt_q       <= '0;
      line_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      line_q      <= line_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/eis_datapath.sv =====
// ----------------------------------------------------------------------------
// eis_datapath
// matrix registers, line coefficients, multipliers, divider and counter
// ----------------------------------------------------------------------------
`default_nettype none

module eis_datapath (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [eis_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [eis_pkg::F_W-1:0]        cfg_data_i,
  input  wire logic [eis_pkg::COORD_W-1:0]    first_x_i,
  input  wire logic [eis_pkg::COORD_W-1:0]    first_y_i,
  input  wire logic [eis_pkg::COORD_W-1:0]    second_x_i,
  input  wire logic [eis_pkg::COORD_W-1:0]    second_y_i,
  input  wire logic                           last_pair_i,
  input  eis_pkg::cmd_t                       cmd_i,
  output eis_pkg::status_t                    status_o,
  output logic                                is_inlier_o,
  output logic [eis_pkg::ERR_W-1:0]           squared_error_o,
  output logic [eis_pkg::TOTAL_W-1:0]         inlier_total_o,
  output logic                                degenerate_o,
  output logic                                final_pair_o
);

  localparam logic signed [eis_pkg::COEF_W-1:0] ONE_Q40 = 62'sd1099511627776;

  logic signed [eis_pkg::F_W-1:0]      f_q [eis_pkg::NUM_REGS];
  logic [eis_pkg::COORD_W-1:0]         x1_q, y1_q, x2_q, y2_q;
  logic                                last_q;
  logic signed [eis_pkg::COEF_W-1:0]   coef_q [3];
  logic [eis_pkg::MAG_W-1:0]           ma_q, mb_q, mc_q;
  logic                                sa_q, sb_q, sc_q;
  logic signed [eis_pkg::NUM_W-1:0]    num_q;
  logic [eis_pkg::N2_W-1:0]            n2_q;
  logic [eis_pkg::SQ_W-1:0]            sq_q;
  logic [eis_pkg::REM_W-1:0]           rem_q;
  logic [eis_pkg::DVS_W-1:0]           dvs_q;
  logic [eis_pkg::ERR_W-1:0]           quo_q;
  logic                                sat_q;
  logic [eis_pkg::ERR_W-1:0]           t0_q, t1_q;
  logic                                degen_q;
  logic [eis_pkg::COUNT_BITS-1:0]      count_q;

  logic [eis_pkg::FIDX_W-1:0]          fx_idx, fy_idx, fc_idx;
  logic signed [eis_pkg::F_W-1:0]      f_mul;
  logic signed [eis_pkg::F_W-1:0]      f_cst;
  logic signed [eis_pkg::COEF_W-1:0]   f_const;
  logic [eis_pkg::COORD_W-1:0]         px, py, qx, qy;
  logic signed [64:0]                  prod_f;
  logic signed [eis_pkg::COEF_W-1:0]   prod_f_sh;
  logic signed [30:0]                  lin_mag, lin_val;
  logic signed [47:0]                  prod_l;
  logic [46:0]                         mc_clamp;
  logic signed [eis_pkg::NUM_W-1:0]    c_term;
  logic [eis_pkg::NMAG_W-1:0]          nmag;
  logic [eis_pkg::CHUNK_W-1:0]         chunk;
  logic [67:0]                         prod_sq;
  logic [59:0]                         prod_n2;
  logic [eis_pkg::SQ_W-1:0]            sq_limit;
  logic                                rem_ge;
  logic [32:0]                         err_sum;
  logic [eis_pkg::ERR_W-1:0]           err_val;
  logic                                inl;
  logic [eis_pkg::COUNT_BITS-1:0]      count_nx;

  function automatic logic signed [eis_pkg::F_W-1:0] f_read(
      input logic signed [eis_pkg::F_W-1:0] regs [eis_pkg::NUM_REGS],
      input logic [eis_pkg::FIDX_W-1:0] idx);
    logic signed [eis_pkg::F_W-1:0] r;
    r = '0;
    if (idx < eis_pkg::FIDX_ONE) r = regs[idx[2:0]];
    return r;
  endfunction

  assign fx_idx = eis_pkg::f_index(cmd_i.line, cmd_i.sel, 2'd0);
  assign fy_idx = eis_pkg::f_index(cmd_i.line, cmd_i.sel, 2'd1);
  assign fc_idx = eis_pkg::f_index(cmd_i.line, cmd_i.sel, 2'd2);

  assign f_mul   = (cmd_i.op == eis_pkg::OP_COEF_Y) ? f_read(f_q, fy_idx) : f_read(f_q, fx_idx);
  assign f_cst   = f_read(f_q, fc_idx);
  assign f_const = (fc_idx == eis_pkg::FIDX_ONE) ? ONE_Q40
                 : {{(eis_pkg::COEF_W - eis_pkg::F_W){f_cst[eis_pkg::F_W-1]}}, f_cst};

  // coefficient coordinates come from one point, the distance from the other
  assign px = cmd_i.line ? x2_q : x1_q;
  assign py = cmd_i.line ? y2_q : y1_q;
  assign qx = cmd_i.line ? x1_q : x2_q;
  assign qy = cmd_i.line ? y1_q : y2_q;

  assign prod_f    = f_mul * $signed({1'b0, (cmd_i.op == eis_pkg::OP_COEF_Y) ? py : px});
  assign prod_f_sh = eis_pkg::COEF_W'(prod_f >>> 4);

  assign lin_mag = $signed({1'b0, (cmd_i.op == eis_pkg::OP_NUM_B) ? mb_q[29:0] : ma_q[29:0]});
  assign lin_val = ((cmd_i.op == eis_pkg::OP_NUM_B) ? sb_q : sa_q) ? -lin_mag : lin_mag;
  assign prod_l  = lin_val * $signed({1'b0, (cmd_i.op == eis_pkg::OP_NUM_B) ? qy : qx});

  assign mc_clamp = (mc_q > eis_pkg::MAG_W'(eis_pkg::C_LIMIT)) ? eis_pkg::C_LIMIT : mc_q[46:0];
  assign c_term   = sc_q ? -$signed({2'b00, mc_clamp, 4'b0000})
                         :  $signed({2'b00, mc_clamp, 4'b0000});

  assign nmag = num_q[eis_pkg::NUM_W-1] ? eis_pkg::NMAG_W'(-num_q)
                                        : eis_pkg::NMAG_W'(num_q);
  always_comb begin
    case (cmd_i.sel)
      2'd0:    chunk = nmag[16:0];
      2'd1:    chunk = nmag[33:17];
      default: chunk = nmag[50:34];
    endcase
  end
  assign prod_sq = nmag * chunk;

  assign prod_n2 = (cmd_i.op == eis_pkg::OP_N2_B) ? mb_q[29:0] * mb_q[29:0]
                                                  : ma_q[29:0] * ma_q[29:0];

  assign sq_limit = {9'b0, n2_q, 32'b0};
  assign rem_ge   = rem_q >= {1'b0, dvs_q};

  assign status_o.degen     = (coef_q[0] == '0) && (coef_q[1] == '0);
  assign status_o.norm_done = ~|ma_q[eis_pkg::MAG_W-1:30] && ~|mb_q[eis_pkg::MAG_W-1:30];

  assign err_sum  = {1'b0, t0_q} + {1'b0, t1_q};
  assign err_val  = (degen_q || err_sum[32]) ? '1 : err_sum[31:0];
  assign inl      = !degen_q && (err_val < eis_pkg::ERR_LIMIT);
  assign count_nx = (inl && (count_q != '1)) ? count_q + 1'b1 : count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < eis_pkg::NUM_REGS; i++) f_q[i] <= '0;
      count_q <= '0;
    end else begin
      if (cfg_we_i) f_q[cfg_index_i] <= cfg_data_i;
      if (cmd_i.op == eis_pkg::OP_FINISH) count_q <= last_q ? '0 : count_nx;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      eis_pkg::OP_LOAD: begin
        x1_q    <= first_x_i;
        y1_q    <= first_y_i;
        x2_q    <= second_x_i;
        y2_q    <= second_y_i;
        last_q  <= last_pair_i;
        degen_q <= 1'b0;
      end
      eis_pkg::OP_COEF_X: coef_q[cmd_i.sel] <= prod_f_sh + f_const;
      eis_pkg::OP_COEF_Y: coef_q[cmd_i.sel] <= coef_q[cmd_i.sel] + prod_f_sh;
      eis_pkg::OP_NORM_INIT: begin
        ma_q    <= eis_pkg::MAG_W'(coef_q[0][eis_pkg::COEF_W-1] ? -coef_q[0] : coef_q[0]);
        mb_q    <= eis_pkg::MAG_W'(coef_q[1][eis_pkg::COEF_W-1] ? -coef_q[1] : coef_q[1]);
        mc_q    <= eis_pkg::MAG_W'(coef_q[2][eis_pkg::COEF_W-1] ? -coef_q[2] : coef_q[2]);
        sa_q    <= coef_q[0][eis_pkg::COEF_W-1];
        sb_q    <= coef_q[1][eis_pkg::COEF_W-1];
        sc_q    <= coef_q[2][eis_pkg::COEF_W-1];
        degen_q <= degen_q | status_o.degen;
      end
      eis_pkg::OP_NORM_STEP: begin
        if (|ma_q[eis_pkg::MAG_W-1:33] || |mb_q[eis_pkg::MAG_W-1:33]) begin
          ma_q <= ma_q >> 4;
          mb_q <= mb_q >> 4;
          mc_q <= mc_q >> 4;
        end else begin
          ma_q <= ma_q >> 1;
          mb_q <= mb_q >> 1;
          mc_q <= mc_q >> 1;
        end
      end
      eis_pkg::OP_NUM_C: num_q <= c_term;
      eis_pkg::OP_NUM_A,
      eis_pkg::OP_NUM_B: num_q <= num_q + eis_pkg::NUM_W'(prod_l);
      eis_pkg::OP_N2_A:  n2_q <= eis_pkg::N2_W'(prod_n2);
      eis_pkg::OP_N2_B:  n2_q <= n2_q + eis_pkg::N2_W'(prod_n2);
      eis_pkg::OP_SQ: begin
        case (cmd_i.sel)
          2'd0:    sq_q <= eis_pkg::SQ_W'(prod_sq);
          2'd1:    sq_q <= sq_q + {17'b0, prod_sq, 17'b0};
          default: sq_q <= sq_q + {prod_sq, 34'b0};
        endcase
      end
      eis_pkg::OP_DIV_INIT: begin
        sat_q <= sq_q >= sq_limit;
        rem_q <= sq_q[eis_pkg::REM_W-1:0];
        dvs_q <= {n2_q, 31'b0};
        quo_q <= '0;
      end
      eis_pkg::OP_DIV_STEP: begin
        if (rem_ge) rem_q <= rem_q - {1'b0, dvs_q};
        quo_q <= {quo_q[eis_pkg::ERR_W-2:0], rem_ge};
        dvs_q <= dvs_q >> 1;
      end
      eis_pkg::OP_TERM: begin
        if (cmd_i.line) t1_q <= sat_q ? '1 : quo_q;
        else t0_q <= sat_q ? '1 : quo_q;
      end
      eis_pkg::OP_FINISH: begin
        is_inlier_o     <= inl;
        squared_error_o <= err_val;
        inlier_total_o  <= (32'(count_nx) > 32'hFFFF) ? '1 : eis_pkg::TOTAL_W'(count_nx);
        degenerate_o    <= degen_q;
        final_pair_o    <= last_q;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/epipolar_inlier_scorer_core.sv =====
// sequence: a request is accepted, then each of the two lines of a pair runs
//   its coefficient, normalize, product and radix-2 divide steps, and a finish
//   step issues the result; a degenerate line skips its remaining steps
// a new pair is accepted only when idle, after the result of the last one has
//   been issued; most of the work is the radix-2 divider and sequenced multiplies
// reset: asynchronous active low; matrix entries and inlier count clear to 0
// ----------------------------------------------------------------------------
// epipolar_inlier_scorer_core
// symmetric epipolar error and inlier count of point pairs against a matrix
// ----------------------------------------------------------------------------
`default_nettype none

module epipolar_inlier_scorer_core (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [eis_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [eis_pkg::F_W-1:0]        cfg_data_i,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic [eis_pkg::COORD_W-1:0]    first_x_i,
  input  wire logic [eis_pkg::COORD_W-1:0]    first_y_i,
  input  wire logic [eis_pkg::COORD_W-1:0]    second_x_i,
  input  wire logic [eis_pkg::COORD_W-1:0]    second_y_i,
  input  wire logic                           last_pair_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic                                is_inlier_o,
  output logic [eis_pkg::ERR_W-1:0]           squared_error_o,
  output logic [eis_pkg::TOTAL_W-1:0]         inlier_total_o,
  output logic                                degenerate_o,
  output logic                                final_pair_o
);

  eis_pkg::cmd_t    cmd;
  eis_pkg::status_t status;

  assign cfg_ready_o = 1'b1;

  eis_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  eis_datapath u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_valid_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .first_x_i       (first_x_i),
    .first_y_i       (first_y_i),
    .second_x_i      (second_x_i),
    .second_y_i      (second_y_i),
    .last_pair_i     (last_pair_i),
    .cmd_i           (cmd),
    .status_o        (status),
    .is_inlier_o     (is_inlier_o),
    .squared_error_o (squared_error_o),
    .inlier_total_o  (inlier_total_o),
    .degenerate_o    (degenerate_o),
    .final_pair_o    (final_pair_o)
  );

endmodule

`default_nettype wire

// ===== rtl/eis_checker.sv =====
// ----------------------------------------------------------------------------
// eis_checker
// port level checks of the scorer, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module eis_checker (
  input wire logic                           clk_i,
  input wire logic                           rst_ni,
  input wire logic                           in_valid_i,
  input wire logic                           in_ready_o,
  input wire logic                           out_valid_o,
  input wire logic                           out_ready_i,
  input wire logic                           is_inlier_o,
  input wire logic [eis_pkg::ERR_W-1:0]      squared_error_o,
  input wire logic [eis_pkg::TOTAL_W-1:0]    inlier_total_o,
  input wire logic                           degenerate_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request taken while busy");

  a_degen_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && degenerate_o |-> squared_error_o == '1 && !is_inlier_o)
    else $error("degenerate result not saturated");

  a_inlier_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !degenerate_o |-> is_inlier_o == (squared_error_o < eis_pkg::ERR_LIMIT))
    else $error("inlier flag disagrees with error");

  a_inlier_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_inlier_o |-> inlier_total_o != '0)
    else $error("inlier with zero total");

endmodule

bind epipolar_inlier_scorer_core eis_checker u_eis_checker (.*);

`default_nettype wire
